// File: rtl/kcr_pkg.sv
// Shared types and constants of the keyframe color ramp.
// Used by every module of the block; depends on nothing.
`default_nettype none

package kcr_pkg;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_KF_DEF = 5;
  localparam int unsigned TIME_W_DEF = 16;

  // Fixed field widths.
  localparam int unsigned KEY_W      = 12;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned LIFE_W     = 16;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned KF_CNT_W   = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;
  localparam int unsigned NUM_CH     = 4;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_COLORS = 5;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // 1.0 in Q1.11.
  localparam logic [KEY_W-1:0]   ONE_Q      = 12'd2048;
  localparam logic [COLOR_W-1:0] WHITE_RGBA = 32'hFFFF_FFFF;

  // Register reset values.
  localparam logic [NUM_COLORS-1:0][COLOR_W-1:0] COLOR_RESET = {
    32'h0000_00FF, 32'h0000_FFFF, 32'h00FF_00FF, 32'hFF00_00FF, 32'hFFFF_FFFF
  };
  localparam logic [CFG_DATA_W-1:0] KEYS_RESET   = 60'h800_600_400_200_000;
  localparam logic [LIFE_W-1:0]     LIFE_RESET   = 16'd1000;
  localparam logic [KF_CNT_W-1:0]   KF_CNT_RESET = 3'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_ZERO     = 3'd0,
    REG_COLOR_ONE      = 3'd1,
    REG_COLOR_TWO      = 3'd2,
    REG_COLOR_THREE    = 3'd3,
    REG_COLOR_FOUR     = 3'd4,
    REG_KEY_POSITIONS  = 3'd5,
    REG_LIFE_TICKS     = 3'd6,
    REG_KEYFRAME_COUNT = 3'd7
  } cfg_reg_e;

  // One classified segment, handed from the front to the back.
  typedef struct packed {
    logic [COLOR_W-1:0]     start_color;
    logic [COLOR_W-1:0]     end_color;
    logic [KEY_W-1:0]       pos;
    logic signed [KEY_W:0]  den;
    logic                   expired;
  } seg_t;

endpackage

`default_nettype wire

// File: rtl/kcr_front.sv
// Front of the keyframe color ramp: elapsed time, life fraction and keyframe search.
// Depends on kcr_pkg.
`default_nettype none

module kcr_front #(
  parameter int unsigned MAX_KEYFRAMES = kcr_pkg::MAX_KF_DEF,
  parameter int unsigned TIME_WIDTH    = kcr_pkg::TIME_W_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       step_valid_i,
  output logic                                       step_ready_o,
  input  logic [kcr_pkg::STEP_W-1:0]                 step_ticks_i,
  input  logic [MAX_KEYFRAMES-1:0][kcr_pkg::COLOR_W-1:0] colors_i,
  input  logic [MAX_KEYFRAMES*kcr_pkg::KEY_W-1:0]    keys_i,
  input  logic [kcr_pkg::LIFE_W-1:0]                 life_i,
  input  logic [kcr_pkg::KF_CNT_W-1:0]               kf_count_i,
  output logic                                       push_valid_o,
  input  logic                                       push_ready_i,
  output kcr_pkg::seg_t                              push_data_o
);
  import kcr_pkg::*;

  localparam int unsigned SumW    = ((TIME_WIDTH > STEP_W) ? TIME_WIDTH : STEP_W) + 1;
  localparam int unsigned RemW    = LIFE_W + 1;
  localparam int unsigned DivCntW = $clog2(KEY_W);
  localparam logic [SumW-1:0] TimeMax = {{(SumW-TIME_WIDTH){1'b0}}, {TIME_WIDTH{1'b1}}};
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(KEY_W - 1);

  typedef enum logic [1:0] {F_IDLE, F_ADD, F_DIV, F_SRCH} state_e;

  state_e                state_q;
  logic [STEP_W-1:0]     step_q;
  logic [TIME_WIDTH-1:0] elapsed_q;
  logic [RemW-1:0]       rem_q;
  logic [KEY_W-1:0]      quo_q;
  logic [DivCntW-1:0]    cnt_q;
  logic                  expired_q;

  // Saturating time update.
  logic [SumW-1:0] sum, sat_life, sat_d;
  always_comb begin
    sum      = SumW'(elapsed_q) + SumW'(step_q);
    sat_life = (sum > SumW'(life_i)) ? SumW'(life_i) : sum;
    sat_d    = (sat_life > TimeMax) ? TimeMax : sat_life;
  end

  // One restoring step of elapsed * 2048 / life.
  logic [RemW-1:0] trial, rem_d;
  logic            ge;
  always_comb begin
    trial = (cnt_q == '0) ? rem_q : {rem_q[LIFE_W-1:0], 1'b0};
    ge    = trial >= RemW'(life_i);
    rem_d = ge ? (trial - RemW'(life_i)) : trial;
  end

  // Highest keyframe in use whose key is at or below the fraction.
  logic [KF_CNT_W-1:0]       cnt;
  logic [MAX_KEYFRAMES-1:0]  sel;
  logic                      found, has_next;
  logic [COLOR_W-1:0]        sc, ec;
  logic [KEY_W-1:0]          sk, ek;
  always_comb begin
    cnt = (kf_count_i > KF_CNT_W'(MAX_KEYFRAMES)) ? KF_CNT_W'(MAX_KEYFRAMES) : kf_count_i;
    found    = 1'b0;
    has_next = 1'b0;
    sel      = '0;
    sc       = '0;
    ec       = '0;
    sk       = '0;
    ek       = '0;
    for (int i = MAX_KEYFRAMES - 1; i >= 0; i--) begin
      if (!found && (KF_CNT_W'(i) < cnt) && (keys_i[KEY_W*i +: KEY_W] <= quo_q)) begin
        found  = 1'b1;
        sel[i] = 1'b1;
      end
    end
    for (int i = 0; i < MAX_KEYFRAMES; i++) begin
      if (sel[i]) begin
        sc = sc | colors_i[i];
        sk = sk | keys_i[KEY_W*i +: KEY_W];
      end
    end
    for (int i = 1; i < MAX_KEYFRAMES; i++) begin
      if (sel[i-1] && (KF_CNT_W'(i) < cnt)) begin
        ec       = ec | colors_i[i];
        ek       = ek | keys_i[KEY_W*i +: KEY_W];
        has_next = 1'b1;
      end
    end
    // Below the first key the whole ramp is white; past the last key it runs to white.
    if (!found) begin
      sc = WHITE_RGBA;
      sk = '0;
    end
    if (!has_next) begin
      ec = WHITE_RGBA;
      ek = ONE_Q;
    end
  end

  assign step_ready_o             = (state_q == F_IDLE);
  assign push_valid_o             = (state_q == F_SRCH);
  assign push_data_o.start_color  = sc;
  assign push_data_o.end_color    = ec;
  assign push_data_o.pos          = quo_q - sk;
  assign push_data_o.den          = $signed({1'b0, ek}) - $signed({1'b0, sk});
  assign push_data_o.expired      = expired_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      step_q    <= '0;
      elapsed_q <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      expired_q <= 1'b0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (step_valid_i) begin
            step_q  <= step_ticks_i;
            state_q <= F_ADD;
          end
        end
        F_ADD: begin
          elapsed_q <= TIME_WIDTH'(sat_d);
          expired_q <= (sat_d >= SumW'(life_i));
          rem_q     <= RemW'(sat_d);
          cnt_q     <= '0;
          if (life_i == '0) begin
            quo_q   <= ONE_Q;
            state_q <= F_SRCH;
          end else begin
            quo_q   <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          rem_q <= rem_d;
          quo_q <= {quo_q[KEY_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= F_SRCH;
          end
        end
        F_SRCH: begin
          if (push_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/kcr_queue.sv
// Short first-in first-out queue of classified segments between front and back.
// Depends on kcr_pkg.
`default_nettype none

module kcr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  kcr_pkg::seg_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output kcr_pkg::seg_t pop_data_o
);
  import kcr_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  seg_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/kcr_back.sv
// Back of the keyframe color ramp: per-channel linear interpolation and the result register.
// Depends on kcr_pkg.
`default_nettype none

module kcr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  kcr_pkg::seg_t             pop_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [kcr_pkg::CH_W-1:0]  red_o,
  output logic [kcr_pkg::CH_W-1:0]  green_o,
  output logic [kcr_pkg::CH_W-1:0]  blue_o,
  output logic [kcr_pkg::CH_W-1:0]  alpha_o,
  output logic                      expired_o
);
  import kcr_pkg::*;

  localparam int unsigned VW      = KEY_W + CH_W + 3;
  localparam int unsigned RemW    = KEY_W + CH_W;
  localparam int unsigned DivCntW = $clog2(CH_W);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(CH_W - 1);
  localparam logic [CH_W-1:0]    ChMax   = {CH_W{1'b1}};

  typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHK, B_DIV, B_DONE} state_e;

  state_e                 state_q;
  seg_t                   seg_q;
  logic signed [VW-1:0]   v_q     [NUM_CH];
  logic [RemW-1:0]        rem_q   [NUM_CH];
  logic [CH_W-1:0]        quo_q   [NUM_CH];
  logic [NUM_CH-1:0]      ovr_q;
  logic [CH_W-1:0]        ovr_val_q [NUM_CH];
  logic [RemW-1:0]        dsh_q;
  logic [DivCntW-1:0]     cnt_q;
  logic                   out_valid_q;
  logic [CH_W-1:0]        ch_q    [NUM_CH];
  logic                   expired_q;

  // v = s*den + pos*(e-s); channel = floor(v/den) clamped to 0..255, or s when den <= 0.
  logic [CH_W-1:0]        s_ch [NUM_CH];
  logic [CH_W-1:0]        e_ch [NUM_CH];
  logic signed [VW-1:0]   v_d  [NUM_CH];
  logic signed [VW-1:0]   s_w, e_w, den_w, pos_w;
  logic                   den_pos;
  logic [NUM_CH-1:0]      ge;
  always_comb begin
    den_w   = VW'(seg_q.den);
    pos_w   = VW'($signed({1'b0, seg_q.pos}));
    den_pos = !seg_q.den[KEY_W] && (seg_q.den != '0);
    for (int k = 0; k < NUM_CH; k++) begin
      s_ch[k] = seg_q.start_color[COLOR_W-1-CH_W*k -: CH_W];
      e_ch[k] = seg_q.end_color[COLOR_W-1-CH_W*k -: CH_W];
      s_w     = VW'($signed({1'b0, s_ch[k]}));
      e_w     = VW'($signed({1'b0, e_ch[k]}));
      v_d[k]  = (s_w * den_w) + (pos_w * (e_w - s_w));
      ge[k]   = rem_q[k] >= dsh_q;
    end
  end

  // A finished word moves into the output register once that register is free
  // or is being emptied in the same cycle.
  logic out_load;
  assign out_load = (state_q == B_DONE) && (!out_valid_q || out_ready_i);

  assign pop_ready_o = (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign red_o       = ch_q[0];
  assign green_o     = ch_q[1];
  assign blue_o      = ch_q[2];
  assign alpha_o     = ch_q[3];
  assign expired_o   = expired_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      seg_q       <= '0;
      ovr_q       <= '0;
      dsh_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      expired_q   <= 1'b0;
      for (int k = 0; k < NUM_CH; k++) begin
        v_q[k]       <= '0;
        rem_q[k]     <= '0;
        quo_q[k]     <= '0;
        ovr_val_q[k] <= '0;
        ch_q[k]      <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (pop_valid_i) begin
            seg_q   <= pop_data_i;
            state_q <= B_MUL;
          end
        end
        B_MUL: begin
          for (int k = 0; k < NUM_CH; k++) begin
            v_q[k] <= v_d[k];
          end
          state_q <= B_CHK;
        end
        B_CHK: begin
          for (int k = 0; k < NUM_CH; k++) begin
            rem_q[k] <= v_q[k][RemW-1:0];
            quo_q[k] <= '0;
            if (!den_pos) begin
              ovr_q[k]     <= 1'b1;
              ovr_val_q[k] <= s_ch[k];
            end else if (v_q[k][VW-1]) begin
              ovr_q[k]     <= 1'b1;
              ovr_val_q[k] <= '0;
            end else if (v_q[k][VW-2:0] >= ((VW-1)'(seg_q.den[KEY_W-1:0]) << CH_W)) begin
              ovr_q[k]     <= 1'b1;
              ovr_val_q[k] <= ChMax;
            end else begin
              ovr_q[k]     <= 1'b0;
              ovr_val_q[k] <= '0;
            end
          end
          dsh_q   <= RemW'(seg_q.den[KEY_W-1:0]) << (CH_W - 1);
          cnt_q   <= '0;
          state_q <= B_DIV;
        end
        B_DIV: begin
          for (int k = 0; k < NUM_CH; k++) begin
            if (ge[k]) begin
              rem_q[k] <= rem_q[k] - dsh_q;
            end
            quo_q[k] <= {quo_q[k][CH_W-2:0], ge[k]};
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            state_q <= B_DONE;
          end
        end
        B_DONE: begin
          if (out_load) begin
            for (int k = 0; k < NUM_CH; k++) begin
              ch_q[k] <= ovr_q[k] ? ovr_val_q[k] : quo_q[k];
            end
            expired_q <= seg_q.expired;
            state_q   <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/keyframe_color_ramp.sv
// Keyframe color ramp, top level: configuration registers, front, queue and back.
// The front takes a new word only after it has pushed the last one's segment.
// Its 12-step restoring divider for the life fraction sets the pace; the back, which
// takes a new segment only once its result is loaded, sets the pace when life_ticks
// is zero and the front skips the divider.
// Reset: asynchronous, active low; registers take their documented defaults and the
// elapsed time returns to zero. No clearing pass is needed.
`default_nettype none

module keyframe_color_ramp #(
  parameter int unsigned MAX_KEYFRAMES = kcr_pkg::MAX_KF_DEF,
  parameter int unsigned TIME_WIDTH    = kcr_pkg::TIME_W_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [kcr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kcr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Time-step words.
  input  logic                             step_valid_i,
  output logic                             step_ready_o,
  input  logic [kcr_pkg::STEP_W-1:0]       step_ticks_i,
  // Color words.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [kcr_pkg::CH_W-1:0]         red_o,
  output logic [kcr_pkg::CH_W-1:0]         green_o,
  output logic [kcr_pkg::CH_W-1:0]         blue_o,
  output logic [kcr_pkg::CH_W-1:0]         alpha_o,
  output logic                             expired_o
);
  import kcr_pkg::*;

  localparam int unsigned KeysW = MAX_KEYFRAMES * KEY_W;

  // Only the keyframes that can ever be used are stored. Writes to a color
  // slot beyond MAX_KEYFRAMES have no effect on any result, so they are dropped.
  logic [MAX_KEYFRAMES-1:0][COLOR_W-1:0] color_q;
  logic [KeysW-1:0]                      keys_q;
  logic [LIFE_W-1:0]                     life_q;
  logic [KF_CNT_W-1:0]                   kf_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_KEYFRAMES; i++) begin
        color_q[i] <= COLOR_RESET[i];
      end
      keys_q     <= KEYS_RESET[KeysW-1:0];
      life_q     <= LIFE_RESET;
      kf_count_q <= KF_CNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_POSITIONS:  keys_q     <= cfg_data_i[KeysW-1:0];
        REG_LIFE_TICKS:     life_q     <= cfg_data_i[LIFE_W-1:0];
        REG_KEYFRAME_COUNT: kf_count_q <= cfg_data_i[KF_CNT_W-1:0];
        default: begin
          if (cfg_idx_i inside {[REG_COLOR_ZERO:REG_COLOR_FOUR]}) begin
            for (int i = 0; i < MAX_KEYFRAMES; i++) begin
              if (cfg_idx_i == CFG_IDX_W'(int'(REG_COLOR_ZERO) + i)) begin
                color_q[i] <= cfg_data_i[COLOR_W-1:0];
              end
            end
          end
        end
      endcase
    end
  end

  // The front turns each time step into a classified segment: start and end colors,
  // position inside the segment and segment length in Q1.11, and the expired flag.
  logic q_push_valid, q_push_ready;
  logic q_pop_valid, q_pop_ready;
  seg_t q_push_data, q_pop_data;

  kcr_front #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES),
    .TIME_WIDTH    (TIME_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_valid_i (step_valid_i),
    .step_ready_o (step_ready_o),
    .step_ticks_i (step_ticks_i),
    .colors_i     (color_q),
    .keys_i       (keys_q),
    .life_i       (life_q),
    .kf_count_i   (kf_count_q),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  // The queue lets the front take the next word while the back is still
  // interpolating or its result waits to be taken.
  kcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  // The back interpolates all four channels with parallel 8-step dividers and
  // holds the finished word in its output register.
  kcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .expired_o   (expired_o)
  );

  // The front works on one word at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_valid_i && step_ready_o |=> !step_ready_o)
    else $error("front took a word while still busy");

  // The back is busy right after it takes a segment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_pop_ready |=> !q_pop_ready)
    else $error("back took a segment while still busy");

  // The queue holds a segment right after one is pushed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_valid && q_push_ready |=> q_pop_valid)
    else $error("queue empty right after a push");

endmodule

`default_nettype wire

// File: tb/tb_keyframe_color_ramp.sv
// Self-checking testbench for keyframe_color_ramp: a queue-fed driver for time-step
// words, a checking monitor for color words and a bit-accurate color predictor.
// Depends on rtl/kcr_pkg.sv and rtl/keyframe_color_ramp.sv.
`timescale 1ns / 1ps

module tb_keyframe_color_ramp;
  import kcr_pkg::*;

  localparam int unsigned IDLE_PCT    = 11;      // chance in a hundred that a side idles
  localparam int unsigned HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT = 800000;  // watchdog, far above a slow clean run
  localparam int unsigned END_WAIT    = 80;      // settle time after the last color word
  localparam int unsigned RAND_PHASES = 32;
  localparam int unsigned PHASE_ITEMS = 60;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TIME_MAX    = (1 << TIME_W_DEF) - 1;

  // One expected or observed color word.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            expired;
  } ramp_px_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  step_valid_i = 1'b0;
  logic                  step_ready_o;
  logic [STEP_W-1:0]     step_ticks_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [CH_W-1:0]       red_o, green_o, blue_o, alpha_o;
  logic                  expired_o;

  keyframe_color_ramp uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .step_valid_i(step_valid_i),
    .step_ready_o(step_ready_o),
    .step_ticks_i(step_ticks_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .expired_o   (expired_o)
  );

  always #2 clk_i = ~clk_i;

  // Shadow copy of the configuration registers and of the elapsed time.
  logic [COLOR_W-1:0]    shadow_colors [NUM_COLORS];
  logic [CFG_DATA_W-1:0] shadow_keys;
  logic [LIFE_W-1:0]     shadow_life;
  logic [KF_CNT_W-1:0]   shadow_count;
  logic [TIME_W_DEF-1:0] elapsed_q;

  // Time steps waiting to be offered, and the colors they are expected to produce.
  logic [STEP_W-1:0] pend_steps [$];
  ramp_px_t          color_due  [$];

  int unsigned steps_issued = 0;   // words taken from pend_steps by the driver
  int unsigned colors_seen  = 0;   // color words accepted by the monitor
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  bit          steady       = 1'b0;  // when set, neither side idles

  // Linear interpolation of one channel with floor rounding and a 0..255 clamp.
  // A segment of zero or negative length yields the start channel.
  function automatic logic [CH_W-1:0] lerp_channel(input longint s, input longint e,
                                                   input longint pos, input longint den);
    longint v, q;
    if (den <= 0) return s[CH_W-1:0];
    v = s * den + pos * (e - s);
    if (v < 0) q = -((-v + den - 1) / den);
    else q = v / den;
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return q[CH_W-1:0];
  endfunction

  // Advances the shadow elapsed time by one step and returns the color it gives.
  function automatic ramp_px_t predict_color(input logic [STEP_W-1:0] step);
    longint unsigned    sum, frac, key;
    longint             sk, ek;
    int                 cnt, i, k;
    bit                 found;
    logic [COLOR_W-1:0] sc, ec;
    logic [CH_W-1:0]    ch [NUM_CH];
    ramp_px_t           px;
    sum = longint'(elapsed_q) + 64'(step);
    if (sum > shadow_life) sum = 64'(shadow_life);
    if (sum > TIME_MAX) sum = 64'(TIME_MAX);
    elapsed_q = sum[TIME_W_DEF-1:0];
    if (shadow_life == 0) frac = 64'(ONE_Q);
    else frac = (sum * ONE_Q) / shadow_life;
    cnt = (shadow_count > MAX_KF_DEF) ? int'(MAX_KF_DEF) : int'(shadow_count);
    // Without a keyframe at or below the fraction both ends stay white.
    sc = WHITE_RGBA;
    ec = WHITE_RGBA;
    sk = 0;
    ek = 64'(ONE_Q);
    found = 1'b0;
    for (i = cnt - 1; i >= 0; i--) begin
      key = 64'(shadow_keys[KEY_W*i +: KEY_W]);
      if (!found && key <= frac) begin
        found = 1'b1;
        sc = shadow_colors[i];
        sk = longint'(key);
        // The last keyframe in use ramps towards white at 1.0.
        if (i + 1 < cnt) begin
          ec = shadow_colors[i+1];
          ek = longint'(shadow_keys[KEY_W*(i+1) +: KEY_W]);
        end
      end
    end
    for (k = 0; k < NUM_CH; k++) begin
      ch[k] = lerp_channel(longint'(sc[CH_W*(3-k) +: CH_W]), longint'(ec[CH_W*(3-k) +: CH_W]),
                           longint'(frac) - sk, ek - sk);
    end
    px.red     = ch[0];
    px.green   = ch[1];
    px.blue    = ch[2];
    px.alpha   = ch[3];
    px.expired = (sum >= shadow_life);
    return px;
  endfunction

  // Driver: offers pending time steps and predicts each one as it is accepted.
  always @(posedge clk_i) begin
    if (step_valid_i && step_ready_o) color_due = {color_due, predict_color(step_ticks_i)};
    if (step_valid_i && !step_ready_o) begin
      // The word on offer stays put until it is taken.
    end else if (rst_ni && pend_steps.size() != 0 &&
                 (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
      step_ticks_i <= pend_steps.pop_front();
      steps_issued++;
      step_valid_i <= 1'b1;
    end else begin
      step_valid_i <= 1'b0;
    end
  end

  // Monitor: checks every accepted color word against the oldest prediction and
  // throttles the output side, including one long hold-off while the input is busy.
  always @(posedge clk_i) begin
    ramp_px_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = {red_o, green_o, blue_o, alpha_o, expired_o};
      colors_seen++;
      if (color_due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("unexpected color word: r=%0d g=%0d b=%0d a=%0d expired=%0b",
                   got.red, got.green, got.blue, got.alpha, got.expired);
        mismatches++;
      end else begin
        want = color_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.expired !== want.expired) begin
          if (mismatches < MAX_REPORTS)
            $display("word %0d: expected %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                     colors_seen, want.red, want.green, want.blue, want.alpha, want.expired,
                     got.red, got.green, got.blue, got.alpha, got.expired);
          mismatches++;
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && colors_seen > 150 && pend_steps.size() > 30) begin
      // Stall the output long enough for the block to back up onto its input.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Random filler above the register width, so that masking is exercised too.
  function automatic logic [CFG_DATA_W-1:0] pad_junk(input logic [CFG_DATA_W-1:0] v,
                                                     input int unsigned w);
    logic [63:0]           junk;
    logic [CFG_DATA_W-1:0] mask;
    junk = {$urandom, $urandom};
    mask = (w >= CFG_DATA_W) ? '1 : ((60'd1 << w) - 60'd1);
    return (junk[CFG_DATA_W-1:0] & ~mask) | (v & mask);
  endfunction

  // One register write, mirrored into the shadow copy. Only called while idle.
  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_KEY_POSITIONS:  shadow_keys  = data;
      REG_LIFE_TICKS:     shadow_life  = data[LIFE_W-1:0];
      REG_KEYFRAME_COUNT: shadow_count = data[KF_CNT_W-1:0];
      default:            shadow_colors[idx] = data[COLOR_W-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(input logic [STEP_W-1:0] s);
    pend_steps = {pend_steps, s};
  endtask

  // The sender holds back until every offered word has come out as a color word.
  task automatic drain();
    while (pend_steps.size() != 0 || steps_issued != colors_seen) @(posedge clk_i);
  endtask

  // A zero lifetime pulls the elapsed time back to zero at the next step.
  task automatic rewind();
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd0, LIFE_W));
    send(STEP_W'($urandom_range(0, 65535)));
    drain();
  endtask

  // Mostly ascending keys inside 0..1.0, with repeats; sometimes pure noise.
  function automatic logic [CFG_DATA_W-1:0] pick_keys();
    logic [63:0]           junk;
    logic [CFG_DATA_W-1:0] keys;
    int unsigned           cur, mode, i;
    mode = $urandom_range(0, 9);
    junk = {$urandom, $urandom};
    if (mode == 0) return junk[CFG_DATA_W-1:0];
    keys = '0;
    cur = (mode < 4) ? 0 : $urandom_range(0, 400);
    for (i = 0; i < NUM_COLORS; i++) begin
      keys[KEY_W*i +: KEY_W] = cur[KEY_W-1:0];
      if ($urandom_range(0, 5) != 0) cur += $urandom_range(0, 700);
      if (cur > ONE_Q) cur = 32'(ONE_Q);
    end
    if (mode == 1) keys[KEY_W*4 +: KEY_W] = ONE_Q;
    return keys;
  endfunction

  function automatic int unsigned pick_life();
    int unsigned mode;
    mode = $urandom_range(0, 19);
    if (mode == 0) return 0;
    if (mode == 1) return 1;
    if (mode == 2) return 65535;
    if (mode < 8) return $urandom_range(2, 64);
    if (mode < 18) return $urandom_range(65, 5000);
    return $urandom_range(5000, 65535);
  endfunction

  function automatic int unsigned pick_count();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(6, 7);
    if (mode == 2) return 1;
    if (mode < 6) return MAX_KF_DEF;
    return $urandom_range(2, 4);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    return $urandom;
  endfunction

  // Steps sized so that a phase walks through the whole lifetime in a few dozen
  // words, plus zero steps and full-range steps that saturate at once.
  function automatic logic [STEP_W-1:0] pick_step(input int unsigned life);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return STEP_W'($urandom_range(0, 65535));
    if (r < 13) return '0;
    return STEP_W'($urandom_range(0, life / 24 + 2));
  endfunction

  initial begin
    int unsigned ph, n, c, life;
    for (c = 0; c < NUM_COLORS; c++) shadow_colors[c] = COLOR_RESET[c];
    shadow_keys  = KEYS_RESET;
    shadow_life  = LIFE_RESET;
    shadow_count = KF_CNT_RESET;
    elapsed_q    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default ramp: first keyframe, mid-segment, exactly on a key, then a step that
    // saturates at the lifetime and lands on the last key at 1.0 (a zero-length
    // segment towards white), and one more step while expired.
    send(16'd0);
    send(16'd125);
    send(16'd125);
    send(16'd250);
    send(16'd250);
    send(16'hFFFF);
    send(16'd0);
    drain();

    // Lifetime lowered below the elapsed time, then raised to its maximum.
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd500, LIFE_W));
    send(16'd0);
    drain();
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd65535, LIFE_W));
    send(16'd1);
    send(16'hFFFF);
    drain();

    // Zero lifetime: the fraction is 1.0 and the word is expired.
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd0, LIFE_W));
    send(16'hA5A5);
    drain();

    // No keyframes in use, then counts above the maximum.
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd100, LIFE_W));
    cfg_write(REG_KEYFRAME_COUNT, pad_junk(60'd0, KF_CNT_W));
    send(16'd10);
    drain();
    cfg_write(REG_KEYFRAME_COUNT, pad_junk(60'd7, KF_CNT_W));
    send(16'd10);
    drain();
    cfg_write(REG_KEYFRAME_COUNT, pad_junk(60'd6, KF_CNT_W));
    send(16'd10);
    drain();

    // First key above the fraction: white until the fraction reaches it.
    cfg_write(REG_KEYFRAME_COUNT, pad_junk(60'd5, KF_CNT_W));
    cfg_write(REG_KEY_POSITIONS, 60'h800_708_5DC_4B0_3E8);
    send(16'd0);
    send(16'd60);
    drain();

    // Register extremes: black and white keyframes, all keys at zero, one keyframe
    // in use and the shortest nonzero lifetime.
    rewind();
    cfg_write(REG_COLOR_ZERO, pad_junk(60'd0, COLOR_W));
    cfg_write(REG_COLOR_ONE, pad_junk(60'hFFFF_FFFF, COLOR_W));
    cfg_write(REG_COLOR_TWO, pad_junk(60'd0, COLOR_W));
    cfg_write(REG_COLOR_THREE, pad_junk(60'hFFFF_FFFF, COLOR_W));
    cfg_write(REG_COLOR_FOUR, pad_junk(60'd0, COLOR_W));
    cfg_write(REG_KEY_POSITIONS, 60'd0);
    cfg_write(REG_KEYFRAME_COUNT, pad_junk(60'd1, KF_CNT_W));
    cfg_write(REG_LIFE_TICKS, pad_junk(60'd1, LIFE_W));
    send(16'd0);
    send(16'd1);
    drain();

    // Random phases: restart the elapsed time, change a random set of registers
    // and walk through the new lifetime. A few middle phases run without idling.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      steady = (ph >= 6 && ph < 10);
      rewind();
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_COLOR_ZERO, pad_junk(CFG_DATA_W'(pick_color()), COLOR_W));
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_COLOR_ONE, pad_junk(CFG_DATA_W'(pick_color()), COLOR_W));
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_COLOR_TWO, pad_junk(CFG_DATA_W'(pick_color()), COLOR_W));
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_COLOR_THREE, pad_junk(CFG_DATA_W'(pick_color()), COLOR_W));
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_COLOR_FOUR, pad_junk(CFG_DATA_W'(pick_color()), COLOR_W));
      if ($urandom_range(0, 2) != 0) cfg_write(REG_KEY_POSITIONS, pick_keys());
      if ($urandom_range(0, 1) != 0)
        cfg_write(REG_KEYFRAME_COUNT, pad_junk(CFG_DATA_W'(pick_count()), KF_CNT_W));
      life = pick_life();
      cfg_write(REG_LIFE_TICKS, pad_junk(CFG_DATA_W'(life), LIFE_W));
      for (n = 0; n < PHASE_ITEMS; n++) send(pick_step(life));
      drain();
    end
    steady = 1'b0;

    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && color_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/kcr_pkg.sv
rtl/kcr_front.sv
rtl/kcr_queue.sv
rtl/kcr_back.sv
rtl/keyframe_color_ramp.sv
tb/tb_keyframe_color_ramp.sv
